// ----- hdl/rail_fence_transposer_macros.svh -----
// ----------------------------------------------------------------------------
// Rail fence transposer assertion macros
// Concurrent assertion helpers that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RAIL_FENCE_TRANSPOSER_MACROS_SVH
`define RAIL_FENCE_TRANSPOSER_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define RFT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define RFT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RFT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RFT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/rft_pkg.sv -----
// ----------------------------------------------------------------------------
// Rail fence transposer package
// Widths, register map, reset values and controller/datapath bundles.
// ----------------------------------------------------------------------------
package rft_pkg;

  localparam int MAX_LEN_DEF = 64;
  localparam int SYM_W       = 8;
  localparam int RAIL_W      = 7;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  // Register indexes (byte address divided by four).
  localparam logic REG_RAIL_COUNT  = 1'b0;
  localparam logic REG_DECODE_MODE = 1'b1;

  localparam logic [RAIL_W-1:0] RAIL_COUNT_RST  = 7'd2;
  localparam logic              DECODE_MODE_RST = 1'b0;

  typedef struct packed {
    logic load;        // store an accepted request
    logic perm_start;  // initialise the position walk
    logic perm_en;     // run the position walk
    logic emit_en;     // stream the result store out
    logic clear;       // message finished, empty the buffer
  } cmd_t;

  typedef struct packed {
    logic perm_done;
    logic wr_busy;
    logic emit_done;
  } sts_t;

endpackage

// ----- hdl/rft_in_if.sv -----
// ----------------------------------------------------------------------------
// Rail fence transposer input channel
// Valid/ready channel carrying one message byte and its last marker.
// ----------------------------------------------------------------------------
interface rft_in_if import rft_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             is_last;

  modport source (output valid, output symbol, output is_last, input ready);
  modport sink   (input valid, input symbol, input is_last, output ready);
endinterface

// ----- hdl/rft_out_if.sv -----
// ----------------------------------------------------------------------------
// Rail fence transposer output channel
// Valid/ready channel carrying one transposed byte with its flags.
// ----------------------------------------------------------------------------
interface rft_out_if import rft_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] out_symbol;
  logic             out_last;
  logic             truncated;

  modport source (output valid, output out_symbol, output out_last, output truncated,
                  input ready);
  modport sink   (input valid, input out_symbol, input out_last, input truncated,
                  output ready);
endinterface

// ----- hdl/rft_cfg.sv -----
// ----------------------------------------------------------------------------
// Rail fence transposer register block
// APB-style register file holding the rail count and the mode bit.
// ----------------------------------------------------------------------------
module rft_cfg import rft_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  output logic [RAIL_W-1:0] rail_count_o,
  output logic              decode_mode_o
);

  logic [RAIL_W-1:0] rail_q;
  logic              decode_q;
  logic              wr_en;
  logic              reg_idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign reg_idx  = paddr_i[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_q   <= RAIL_COUNT_RST;
      decode_q <= DECODE_MODE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RAIL_COUNT:  rail_q   <= pwdata_i[RAIL_W-1:0];
        REG_DECODE_MODE: decode_q <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RAIL_COUNT:  prdata_o = DATA_W'(rail_q);
      REG_DECODE_MODE: prdata_o = DATA_W'(decode_q);
      default:         prdata_o = '0;
    endcase
  end

  assign rail_count_o  = rail_q;
  assign decode_mode_o = decode_q;

endmodule

// ----- hdl/rft_ctrl.sv -----
// ----------------------------------------------------------------------------
// Rail fence transposer controller
// Sequences loading, permutation, write drain and emission of a message.
// ----------------------------------------------------------------------------
module rft_ctrl import rft_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_is_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PERM,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.load = in_fire;
        if (in_fire && in_is_last_i) begin
          cmd_o.perm_start = 1'b1;
          state_d          = ST_PERM;
        end
      end
      ST_PERM: begin
        cmd_o.perm_en = 1'b1;
        if (sts_i.perm_done) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // The last result store write must land before it is read back.
        if (!sts_i.wr_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_en = 1'b1;
        if (sts_i.emit_done) begin
          cmd_o.clear = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/rft_datapath.sv -----
// ----------------------------------------------------------------------------
// Rail fence transposer datapath
// Message and result stores, zigzag position walk and output register.
// ----------------------------------------------------------------------------
module rft_datapath import rft_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [RAIL_W-1:0] rail_count_i,
  input  logic              decode_mode_i,
  input  logic [SYM_W-1:0]  symbol_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [SYM_W-1:0]  out_symbol_o,
  output logic              out_last_o,
  output logic              truncated_o
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int PW = AW + 2;
  localparam int CW = RAIL_W + LW;

  logic [SYM_W-1:0] msg_mem [MAX_LEN];
  logic [SYM_W-1:0] res_mem [MAX_LEN];

  logic [LW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;

  // Position walk state.
  logic [PW-1:0] rail_q, rail_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] step_q, step_d;
  logic [LW-1:0] rank_q, rank_d;

  logic          ident;
  logic [PW-1:0] rails_p, period, step_eff, rail_nxt;
  logic          issue;
  logic [AW-1:0] src_addr, dst_addr;

  logic          wr_v_q;
  logic [AW-1:0] wr_addr_q;
  logic [SYM_W-1:0] msg_rd_q;

  logic [LW-1:0] emit_cnt_q;
  logic          rd_fire;
  logic          out_v_q;
  logic [SYM_W-1:0] res_rd_q;
  logic          out_last_q, trunc_q;

  // ---- Buffer fill -------------------------------------------------------
  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    if (cmd_i.load) begin
      if (fill_q < LW'(MAX_LEN)) fill_d = fill_q + LW'(1);
      else                        ovf_d  = 1'b1;
    end
    if (cmd_i.clear) begin
      fill_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (fill_q < LW'(MAX_LEN))) msg_mem[fill_q[AW-1:0]] <= symbol_i;
  end

  // ---- Zigzag walk -------------------------------------------------------
  // At most one rail, or at least as many rails as bytes, leaves the message as it is.
  assign ident    = (rail_count_i <= RAIL_W'(1)) || (CW'(rail_count_i) >= CW'(fill_q));
  assign rails_p  = PW'(rail_count_i);
  assign period   = (rails_p - PW'(1)) << 1;
  assign step_eff = (step_q == '0) ? period : step_q;
  assign rail_nxt = rail_q + PW'(1);

  assign issue = cmd_i.perm_en && (rank_q != fill_q) && (ident || (pos_q < PW'(fill_q)));

  always_comb begin
    if (ident) begin
      src_addr = rank_q[AW-1:0];
      dst_addr = rank_q[AW-1:0];
    end else if (decode_mode_i) begin
      src_addr = rank_q[AW-1:0];
      dst_addr = pos_q[AW-1:0];
    end else begin
      src_addr = pos_q[AW-1:0];
      dst_addr = rank_q[AW-1:0];
    end
  end

  always_comb begin
    rail_d = rail_q;
    pos_d  = pos_q;
    step_d = step_q;
    rank_d = rank_q;
    if (cmd_i.perm_start) begin
      rail_d = '0;
      pos_d  = '0;
      step_d = period;
      rank_d = '0;
    end else if (issue) begin
      rank_d = rank_q + LW'(1);
      pos_d  = pos_q + step_eff;
      step_d = period - step_eff;
    end else if (cmd_i.perm_en && (rank_q != fill_q)) begin
      // Walked off the end of this rail: start on the next one.
      rail_d = rail_nxt;
      pos_d  = rail_nxt;
      step_d = period - (rail_nxt << 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      msg_rd_q  <= msg_mem[src_addr];
      wr_addr_q <= dst_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_v_q) res_mem[wr_addr_q] <= msg_rd_q;
  end

  // ---- Emission ----------------------------------------------------------
  assign rd_fire = cmd_i.emit_en && (emit_cnt_q != fill_q) && (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      res_rd_q   <= res_mem[emit_cnt_q[AW-1:0]];
      out_last_q <= (emit_cnt_q + LW'(1)) == fill_q;
      trunc_q    <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      ovf_q      <= 1'b0;
      rail_q     <= '0;
      pos_q      <= '0;
      step_q     <= '0;
      rank_q     <= '0;
      wr_v_q     <= 1'b0;
      emit_cnt_q <= '0;
      out_v_q    <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      rail_q <= rail_d;
      pos_q  <= pos_d;
      step_q <= step_d;
      rank_q <= rank_d;
      wr_v_q <= issue;
      if (cmd_i.perm_start)  emit_cnt_q <= '0;
      else if (rd_fire)      emit_cnt_q <= emit_cnt_q + LW'(1);
      if (rd_fire)           out_v_q <= 1'b1;
      else if (out_ready_i)  out_v_q <= 1'b0;
    end
  end

  assign sts_o.perm_done = (rank_q == fill_q);
  assign sts_o.wr_busy   = wr_v_q;
  assign sts_o.emit_done = (emit_cnt_q == fill_q) && !out_v_q;

  assign out_valid_o  = out_v_q;
  assign out_symbol_o = res_rd_q;
  assign out_last_o   = out_last_q;
  assign truncated_o  = trunc_q;

endmodule

// ----- hdl/rail_fence_transposer.sv -----
// Operation: stored bytes load at one per cycle while the input is open; after the last byte
// the zigzag walk visits each position rail by rail, the last result store write lands, and
// then results follow one per cycle while the output is not stalled. Messages do not overlap:
// the input reopens only after the last result of a message has gone out.
// Reset clears the controller, counters, overflow and valid flags and registers (rails 2, encode), not the stores.
// ----------------------------------------------------------------------------
// Rail fence transposer
// Buffers a message and emits its rail fence encoding or decoding.
// ----------------------------------------------------------------------------
`include "rail_fence_transposer_macros.svh"

module rail_fence_transposer import rft_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  rft_in_if.sink            in_i,
  rft_out_if.source         out_o
);

  cmd_t              cmd;
  sts_t              sts;
  logic [RAIL_W-1:0] rail_count;
  logic              decode_mode;

  rft_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_o      (prdata),
    .pready_o      (pready),
    .rail_count_o  (rail_count),
    .decode_mode_o (decode_mode)
  );

  rft_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_is_last_i (in_i.is_last),
    .in_ready_o   (in_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  rft_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rail_count_i  (rail_count),
    .decode_mode_i (decode_mode),
    .symbol_i      (in_i.symbol),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_symbol_o  (out_o.out_symbol),
    .out_last_o    (out_o.out_last),
    .truncated_o   (out_o.truncated)
  );

  // Loading and emission never overlap.
  `RFT_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, in_i.ready, !out_o.valid)
  // A last byte accepted ends loading until the message has gone out.
  `RFT_ASSERT_NXT(a_last_stops_load, clk_i, rst_ni,
                  in_i.valid && in_i.ready && in_i.is_last, !in_i.ready)
  // Nothing follows the final result of a message.
  `RFT_ASSERT_NXT(a_last_ends_burst, clk_i, rst_ni,
                  out_o.valid && out_o.ready && out_o.out_last, !out_o.valid)

endmodule
